>>> rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package pmt_pkg;

    // Width of the reported pointer coordinates
    localparam int unsigned POS_W  = 12;
    // Width of the screen size registers
    localparam int unsigned SIZE_W = 13;
    // Width of one signed motion delta after negation (-255 .. 256)
    localparam int unsigned DELTA_W = 10;

    localparam logic [7:0] ACK_BYTE  = 8'hFA;
    localparam logic [7:0] HDR_MASK  = 8'hC8;
    localparam logic [7:0] HDR_MATCH = 8'h08;

    // Header bit positions
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [8:0]        RST_POS_X  = 9'd320;
    localparam logic [8:0]        RST_POS_Y  = 9'd240;

    typedef enum logic [1:0] {
        PH_WAIT_ACK = 2'd0,
        PH_HEADER   = 2'd1,
        PH_DX       = 2'd2,
        PH_DY       = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_RELEASED = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_MOVED    = 2'd2,
        EV_DRAGGED  = 2'd3
    } t_event;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

>>> rtl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Frames PS/2 mouse bytes into three-byte packets and tracks a clamped pointer.
// Throughput: one byte per cycle; the input register and the output register
// form a two-stage pipeline that stalls only when the output is held.
// Reset (synchronous, active low) empties both stages, waits for acknowledge,
// sets the pointer to 320/240 and the screen size to 640x480.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pmt_pkg::SIZE_W-1:0]  i_cfg_data,

    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_data_byte,

    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pmt_pkg::POS_W-1:0]   o_pos_x,
    output logic [pmt_pkg::POS_W-1:0]   o_pos_y,
    output logic [2:0]                  o_buttons,
    output logic [1:0]                  o_event_res
);

    // The pointer register must also hold the reset position (9 bits).
    localparam int unsigned PW = (COORD_BITS > 9) ? COORD_BITS : 9;
    localparam int unsigned AW = ((PW > pmt_pkg::SIZE_W) ? PW : pmt_pkg::SIZE_W) + 2;
    localparam int unsigned DW = pmt_pkg::DELTA_W;

    logic [pmt_pkg::SIZE_W-1:0] r_width;
    logic [pmt_pkg::SIZE_W-1:0] r_height;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    pmt_pkg::t_phase  r_phase, n_phase;
    logic [7:0]       r_header, n_header;
    logic [7:0]       r_dx_byte, n_dx_byte;
    logic [PW-1:0]    r_cur_x, n_cur_x;
    logic [PW-1:0]    r_cur_y, n_cur_y;

    logic             r_out_valid, n_out_valid;
    logic [pmt_pkg::POS_W-1:0] r_pos_x, n_pos_x;
    logic [pmt_pkg::POS_W-1:0] r_pos_y, n_pos_y;
    logic [2:0]       r_buttons, n_buttons;
    pmt_pkg::t_event  r_event, n_event;

    logic             out_free;
    logic             s1_adv;
    logic             pkt_done;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [PW+pmt_pkg::POS_W-1:0] x_ext;
    logic [PW+pmt_pkg::POS_W-1:0] y_ext;

    // Adds a signed delta, clears bit 0 and clamps to [0, min(size, 2^COORD_BITS) - 1].
    function automatic logic [PW-1:0] axis_update(
        input logic [PW-1:0]               pos,
        input logic signed [DW-1:0]        delta,
        input logic [pmt_pkg::SIZE_W-1:0]  size
    );
        logic [AW-1:0] cap;
        logic [AW-1:0] sz;
        logic [AW-1:0] lim;
        logic [AW-1:0] sum;
        logic [AW-1:0] u;
        cap = {{(AW-1){1'b0}}, 1'b1} << COORD_BITS;
        sz  = {{(AW-pmt_pkg::SIZE_W){1'b0}}, size};
        if (sz > cap) begin
            sz = cap;
        end
        lim = (sz == '0) ? '0 : sz - {{(AW-1){1'b0}}, 1'b1};
        sum = {{(AW-PW){1'b0}}, pos} + {{(AW-DW){delta[DW-1]}}, delta};
        if (sum[AW-1]) begin
            u = '0;
        end else begin
            u = {sum[AW-1:1], 1'b0};
            if (u > lim) begin
                u = lim;
            end
        end
        return u[PW-1:0];
    endfunction

    // The first stage moves on whenever the result register is free or being emptied.
    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    assign pkt_done = s1_adv && (r_phase == pmt_pkg::PH_DY);

    always_comb begin
        dx = {1'b0, r_header[pmt_pkg::X_SIGN_BIT], r_dx_byte};
        dy = -$signed({1'b0, r_header[pmt_pkg::Y_SIGN_BIT], r_in_byte});
        if (r_header[pmt_pkg::X_SIGN_BIT]) begin
            dx = $signed({2'b11, r_dx_byte});
        end
        if (r_header[pmt_pkg::Y_SIGN_BIT]) begin
            dy = -$signed({2'b11, r_in_byte});
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_header  = r_header;
        n_dx_byte = r_dx_byte;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        if (s1_adv) begin
            case (r_phase)
                pmt_pkg::PH_WAIT_ACK: begin
                    if (r_in_byte == pmt_pkg::ACK_BYTE) begin
                        n_phase = pmt_pkg::PH_HEADER;
                    end
                end
                pmt_pkg::PH_HEADER: begin
                    if ((r_in_byte & pmt_pkg::HDR_MASK) == pmt_pkg::HDR_MATCH) begin
                        n_header = r_in_byte;
                        n_phase  = pmt_pkg::PH_DX;
                    end
                end
                pmt_pkg::PH_DX: begin
                    n_dx_byte = r_in_byte;
                    n_phase   = pmt_pkg::PH_DY;
                end
                pmt_pkg::PH_DY: begin
                    n_phase = pmt_pkg::PH_HEADER;
                    n_cur_x = axis_update(r_cur_x, dx, r_width);
                    n_cur_y = axis_update(r_cur_y, dy, r_height);
                end
                default: begin
                    n_phase = pmt_pkg::PH_WAIT_ACK;
                end
            endcase
        end
    end

    assign x_ext = {{pmt_pkg::POS_W{1'b0}}, n_cur_x};
    assign y_ext = {{pmt_pkg::POS_W{1'b0}}, n_cur_y};

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_buttons   = r_buttons;
        n_event     = r_event;
        if (pkt_done) begin
            n_out_valid = 1'b1;
            n_pos_x     = x_ext[pmt_pkg::POS_W-1:0];
            n_pos_y     = y_ext[pmt_pkg::POS_W-1:0];
            n_buttons   = r_header[2:0];
            if ((dx == '0) && (dy == '0)) begin
                n_event = (r_header[2:0] == 3'd0) ? pmt_pkg::EV_RELEASED
                                                  : pmt_pkg::EV_PRESSED;
            end else begin
                n_event = (r_header[2:0] == 3'd0) ? pmt_pkg::EV_MOVED
                                                  : pmt_pkg::EV_DRAGGED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pmt_pkg::RST_WIDTH;
            r_height <= pmt_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (pmt_pkg::t_cfg_reg'(i_cfg_idx))
                pmt_pkg::REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                pmt_pkg::REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pmt_pkg::PH_WAIT_ACK;
            r_header    <= 8'd0;
            r_dx_byte   <= 8'd0;
            r_cur_x     <= PW'(pmt_pkg::RST_POS_X);
            r_cur_y     <= PW'(pmt_pkg::RST_POS_Y);
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_header    <= n_header;
            r_dx_byte   <= n_dx_byte;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_out_valid <= n_out_valid;
        end
        r_pos_x   <= n_pos_x;
        r_pos_y   <= n_pos_y;
        r_buttons <= n_buttons;
        r_event   <= n_event;
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_buttons   = r_buttons;
    assign o_event_res = r_event;

endmodule

>>> rtl/pmt_checker.sv
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks for the PS/2 mouse packet tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [11:0] o_pos_x,
    input logic [11:0] o_pos_y,
    input logic [2:0]  o_buttons,
    input logic [1:0]  o_event_res
);

    // A result that has not been taken stays on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result withdrawn before its transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_pos_x) && $stable(o_pos_y)
                                && $stable(o_buttons) && $stable(o_event_res))
        else $error("result changed while stalled");

    // The low event bit says whether any button is held.
    a_event_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_buttons == 3'd0) == (o_event_res[0] == 1'b0)))
        else $error("event class disagrees with buttons");

    // A result only appears after an input transfer.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result without a preceding input transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind ps2_mouse_packet_tracker pmt_checker u_pmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y),
    .o_buttons   (o_buttons),
    .o_event_res (o_event_res)
);

>>> test/tb_ps2_mouse_packet_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker
// Sends mouse byte streams into the packet tracker and compares every pointer
// report with a behavioural tracker kept in the bench. The streams cover the
// acknowledge wait, header rejection, sign handling, clamping at many screen
// sizes, random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker;

    localparam int PIPE_LATENCY = 2;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int COORD_CAP    = 1 << pmt_pkg::POS_W;

    typedef struct {
        logic [pmt_pkg::POS_W-1:0] pos_x;
        logic [pmt_pkg::POS_W-1:0] pos_y;
        logic [2:0]                buttons;
        pmt_pkg::t_event           ev;
    } t_pointer_report;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic                        i_cfg_idx   = pmt_pkg::REG_SCREEN_WIDTH;
    logic [pmt_pkg::SIZE_W-1:0]  i_cfg_data  = '0;
    logic                        i_valid     = 1'b0;
    logic                        o_ready;
    logic [7:0]                  i_data_byte = '0;
    logic                        o_valid;
    logic                        i_ready     = 1'b0;
    logic [pmt_pkg::POS_W-1:0]   o_pos_x;
    logic [pmt_pkg::POS_W-1:0]   o_pos_y;
    logic [2:0]                  o_buttons;
    logic [1:0]                  o_event_res;

    t_pointer_report    expected_reports[$];

    // Tracker state mirrored in the bench
    pmt_pkg::t_phase             trk_phase;
    logic [7:0]                  trk_header;
    logic [7:0]                  trk_dx;
    logic [pmt_pkg::POS_W-1:0]   trk_x;
    logic [pmt_pkg::POS_W-1:0]   trk_y;
    logic [pmt_pkg::SIZE_W-1:0]  trk_width;
    logic [pmt_pkg::SIZE_W-1:0]  trk_height;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;

    ps2_mouse_packet_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_buttons   (o_buttons),
        .o_event_res (o_event_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void reset_tracker();
        trk_phase  = pmt_pkg::PH_WAIT_ACK;
        trk_header = '0;
        trk_dx     = '0;
        trk_x      = pmt_pkg::POS_W'(pmt_pkg::RST_POS_X);
        trk_y      = pmt_pkg::POS_W'(pmt_pkg::RST_POS_Y);
        trk_width  = pmt_pkg::RST_WIDTH;
        trk_height = pmt_pkg::RST_HEIGHT;
    endfunction

    // Adds a delta to one coordinate; the low bit is cleared before the
    // clamp, so a clamped coordinate may still be odd.
    function automatic logic [pmt_pkg::POS_W-1:0] step_axis(
        logic [pmt_pkg::POS_W-1:0] pos, int delta, logic [pmt_pkg::SIZE_W-1:0] size);
        int lim;
        int sum;
        if (size > COORD_CAP) begin
            lim = COORD_CAP - 1;
        end else if (size == 0) begin
            lim = 0;
        end else begin
            lim = int'(size) - 1;
        end
        sum = int'(pos) + delta;
        if (sum < 0)
            return '0;
        sum = sum & ~1;
        if (sum > lim)
            sum = lim;
        return sum[pmt_pkg::POS_W-1:0];
    endfunction

    function automatic void track_byte(logic [7:0] b);
        int              dx;
        int              dy;
        logic [2:0]      btn;
        t_pointer_report rep;
        case (trk_phase)
            pmt_pkg::PH_WAIT_ACK: begin
                if (b == pmt_pkg::ACK_BYTE)
                    trk_phase = pmt_pkg::PH_HEADER;
            end
            pmt_pkg::PH_HEADER: begin
                if ((b & pmt_pkg::HDR_MASK) == pmt_pkg::HDR_MATCH) begin
                    trk_header = b;
                    trk_phase  = pmt_pkg::PH_DX;
                end
            end
            pmt_pkg::PH_DX: begin
                trk_dx    = b;
                trk_phase = pmt_pkg::PH_DY;
            end
            default: begin
                trk_phase = pmt_pkg::PH_HEADER;
                btn = trk_header[2:0];
                dx  = int'(trk_dx) - (trk_header[pmt_pkg::X_SIGN_BIT] ? 256 : 0);
                dy  = -(int'(b) - (trk_header[pmt_pkg::Y_SIGN_BIT] ? 256 : 0));
                if (dx == 0 && dy == 0)
                    rep.ev = (btn == 0) ? pmt_pkg::EV_RELEASED : pmt_pkg::EV_PRESSED;
                else
                    rep.ev = (btn == 0) ? pmt_pkg::EV_MOVED : pmt_pkg::EV_DRAGGED;
                trk_x = step_axis(trk_x, dx, trk_width);
                trk_y = step_axis(trk_y, dy, trk_height);
                rep.pos_x   = trk_x;
                rep.pos_y   = trk_y;
                rep.buttons = btn;
                expected_reports.push_back(rep);
            end
        endcase
    endfunction

    // Receiver: random stalls, or a long hold-off counted here on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_report
        t_pointer_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual x=%0d y=%0d b=%0d e=%0d",
                         $time, o_pos_x, o_pos_y, o_buttons, o_event_res);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                check_field("pos_x", int'(want.pos_x), int'(o_pos_x));
                check_field("pos_y", int'(want.pos_y), int'(o_pos_y));
                check_field("buttons", int'(want.buttons), int'(o_buttons));
                check_field("event_res", int'(want.ev), int'(o_event_res));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAIL ps2_mouse_packet_tracker");
            $finish;
        end
    end

    // Returns at the edge of the transfer with valid still high, so the
    // caller must either send again or drain without letting time pass.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        track_byte(b);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dxb,
                               input logic [7:0] dyb);
        send_byte(hdr);
        send_byte(dxb);
        send_byte(dyb);
    endtask

    // Well-formed header with random buttons and signs; about a quarter of
    // the axes carry no motion so that released and pressed reports appear.
    task automatic send_random_packet();
        logic [7:0] hdr;
        logic [7:0] dxb;
        logic [7:0] dyb;
        hdr = pmt_pkg::HDR_MATCH | (8'($urandom_range(255)) & ~pmt_pkg::HDR_MASK);
        dxb = 8'($urandom_range(255));
        dyb = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) begin
            hdr[pmt_pkg::X_SIGN_BIT] = 1'b0;
            dxb = '0;
        end
        if ($urandom_range(3) == 0) begin
            hdr[pmt_pkg::Y_SIGN_BIT] = 1'b0;
            dyb = '0;
        end
        send_packet(hdr, dxb, dyb);
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_screen(input logic [pmt_pkg::SIZE_W-1:0] w,
                              input logic [pmt_pkg::SIZE_W-1:0] h);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pmt_pkg::REG_SCREEN_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= pmt_pkg::REG_SCREEN_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        trk_width  = w;
        trk_height = h;
    endtask

    task automatic test_before_ack();
        send_byte(pmt_pkg::HDR_MATCH);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFB);
        send_byte(pmt_pkg::ACK_BYTE);
    endtask

    task automatic test_packet_framing();
        // Rejected headers: the acknowledge itself, overflow bits, bit 3 clear
        send_byte(pmt_pkg::ACK_BYTE);
        send_byte(pmt_pkg::HDR_MATCH | 8'h80);
        send_byte(pmt_pkg::HDR_MATCH | 8'h40);
        send_byte(8'h07);
        send_packet(pmt_pkg::HDR_MATCH, 8'h00, 8'h00);
        send_packet(pmt_pkg::HDR_MATCH | 8'h07, 8'h00, 8'h00);
        send_packet(pmt_pkg::HDR_MATCH | 8'h10, 8'h00, 8'h00);
        send_packet(pmt_pkg::HDR_MATCH | 8'h20, 8'hFF, 8'h00);
        send_packet(pmt_pkg::HDR_MATCH | 8'h33, 8'hFF, 8'h7F);
        drain_pipeline();
    endtask

    task automatic test_screen_sizes();
        logic [pmt_pkg::SIZE_W-1:0] w_list [8];
        logic [pmt_pkg::SIZE_W-1:0] h_list [8];
        w_list = '{13'd2, 13'd4096, 13'd0, 13'd8191, 13'd1, 13'd4097, 13'd301, 13'd640};
        h_list = '{13'd2, 13'd4096, 13'd1, 13'd3, 13'd8191, 13'd17, 13'd4095, 13'd480};
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        foreach (w_list[i]) begin
            set_screen(w_list[i], h_list[i]);
            repeat (12) send_random_packet();
        end
        drain_pipeline();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        repeat (12) send_random_packet();
        drain_pipeline();
        repeat (8) send_random_packet();
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        int s_pct [4];
        int r_pct [4];
        s_pct = '{0, 45, 0, 13};
        r_pct = '{0, 0, 45, 13};
        set_screen(13'd1024, 13'd768);
        foreach (s_pct[p]) begin
            send_idle_pct  = s_pct[p];
            recv_stall_pct = r_pct[p];
            repeat (45) begin
                // Stray bytes knock the framing out of step now and then.
                if ($urandom_range(9) == 0)
                    send_byte(8'($urandom_range(255)));
                send_random_packet();
            end
        end
        drain_pipeline();
    endtask

    initial begin
        reset_tracker();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_before_ack();
        test_packet_framing();
        test_screen_sizes();
        test_backpressure();
        test_random_traffic();
        drain_pipeline();
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("PASS ps2_mouse_packet_tracker");
        else
            $display("FAIL ps2_mouse_packet_tracker");
        $finish;
    end

endmodule
